>>> rtl/core/ptg_pkg.sv
// Package for the pan-tilt goto step planner.
// Holds the shared types, pipeline sizing and the fixed-point constants.
// No dependencies.
package ptg_pkg;

  // Seven register stages from input to result.
  localparam int NUM_STAGES = 7;
  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // Bias making a signed count positive; a multiple of 600, so mod 600 holds.
  localparam logic [25:0] POS_BIAS  = 26'd16800000;
  // Same bias plus the 90 degree tilt offset (9000 / 60 = 150 steps).
  localparam logic [25:0] TILT_BIAS = 26'd16800150;

  // Remainder by 75 on the step count divided by 8.
  localparam logic [7:0]  MOD_DIV      = 8'd75;
  localparam logic [23:0] MOD_RECIP    = 24'd14316557;  // floor(2^30 / 75)
  localparam int          MOD_SHIFT    = 30;

  // Whole degrees from m = angle / 60: floor(3 * m / 5) = (m * 4917) >> 13.
  localparam logic [12:0] DEG_MUL      = 13'd4917;
  localparam int          DEG_SHIFT    = 13;

  // Steps from degrees: floor(deg * 5 / 3) = (deg * 6830) >> 12.
  localparam logic [12:0] STEP_MUL     = 13'd6830;
  localparam int          STEP_SHIFT   = 12;

  localparam logic [10:0] HALF_TURN_DEG = 11'd180;
  localparam logic [10:0] FULL_TURN_DEG = 11'd360;
  localparam logic [9:0]  ELEV_MAX      = 10'd90;

  // Command fields that ride alongside the angle arithmetic.
  typedef struct packed {
    logic       busy;
    logic [8:0] azimuth;
    logic [6:0] elevation;
  } cmd_t;

  // One angle split into whole degrees and hundredths.
  typedef struct packed {
    logic [8:0] deg;
    logic [6:0] hund;
  } angle_t;

endpackage

>>> rtl/core/pan_tilt_goto_step_planner_core.sv
// Top level of the pan-tilt goto step planner: seven-stage pipeline with valid/stall.
// Depends on ptg_pkg, ptg_mod600, ptg_deg_split and ptg_move_plan.
//
//   Channel   Direction   Handshake            Payload
//   in_*      input       in_valid/in_stall    positions, busy flag, targets
//   out_*     output      out_valid/out_stall  step counts, directions, angles
//
// Every item produces exactly one result item. The edge that accepts an item
// loads the first of seven register stages, and the item moves on through the
// stages in order until it reaches the last one and out_valid rises.
// The pipeline takes one item per cycle; the throughput is set only by out_stall.
// A stage holds its item while the stage after it is full and cannot move, so
// bubbles collapse and in_stall rises only when all seven stages are full.
// Reset (rst_n low at a clock edge) clears the valid bits; the data registers
// are left as they are and carry no meaning until a valid item reaches them.
//
// Data flow: stage 1 biases the step counts so that they are positive multiples
// of the 600-step turn apart, stages 2 and 3 take the remainder by 600 through a
// reciprocal multiply with one correction, stage 4 splits the angle into whole
// degrees and hundredths, stage 5 forms the shortest-way azimuth delta and the
// elevation delta, stage 6 converts degrees to steps, and stage 7 forms the
// net tilt motor move and zeros the result for a busy request.
module pan_tilt_goto_step_planner_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] in_pan_position,
  input  logic [23:0] in_tilt_position,
  input  logic        in_busy_req,
  input  logic [8:0]  in_target_azimuth,
  input  logic [9:0]  in_target_elevation,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [8:0]  out_pan_step_count,
  output logic        out_pan_reverse,
  output logic [9:0]  out_tilt_step_count,
  output logic        out_tilt_reverse,
  output logic [8:0]  out_azimuth_degrees,
  output logic [6:0]  out_azimuth_hundredths,
  output logic [8:0]  out_elevation_degrees,
  output logic [6:0]  out_elevation_hundredths
);

  localparam int CMD_STAGES = 4;

  ptg_pkg::stage_en_t valid_r, valid_nxt;
  ptg_pkg::stage_en_t en;
  ptg_pkg::cmd_t      cmd_r [CMD_STAGES];
  ptg_pkg::cmd_t      cmd_in;

  logic [25:0]     pan_biased, tilt_biased;
  logic [9:0]      pan_residue, tilt_residue;
  ptg_pkg::angle_t az_angle, el_angle, az_final, el_final;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[ptg_pkg::NUM_STAGES-1] = !valid_r[ptg_pkg::NUM_STAGES-1] || !out_stall;
    for (int k = ptg_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
    valid_nxt = valid_r;
    if (en[0]) begin
      valid_nxt[0] = in_valid;
    end
    for (int k = 1; k < ptg_pkg::NUM_STAGES; k++) begin
      if (en[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = valid_r[ptg_pkg::NUM_STAGES-1];

  // The elevation target is clamped to 0..90 on entry.
  always_comb begin
    cmd_in.busy    = in_busy_req;
    cmd_in.azimuth = in_target_azimuth;
    if (in_target_elevation[9]) begin
      cmd_in.elevation = '0;
    end else if (in_target_elevation > ptg_pkg::ELEV_MAX) begin
      cmd_in.elevation = ptg_pkg::ELEV_MAX[6:0];
    end else begin
      cmd_in.elevation = in_target_elevation[6:0];
    end
  end

  // The command fields follow the angle arithmetic through stages 1 to 4.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      cmd_r[0] <= cmd_in;
    end
    for (int k = 1; k < CMD_STAGES; k++) begin
      if (en[k]) begin
        cmd_r[k] <= cmd_r[k-1];
      end
    end
  end

  // Pan angle is 60 * (pan mod 600) hundredths; tilt angle is
  // 60 * ((tilt - pan + 150) mod 600). Each bias, less the 150 offset, is a multiple
  // of 600 and keeps its sum positive, so the wrap of the 26-bit adds is harmless.
  assign pan_biased  = {{2{in_pan_position[23]}}, in_pan_position} + ptg_pkg::POS_BIAS;
  assign tilt_biased = {{2{in_tilt_position[23]}}, in_tilt_position}
                     - {{2{in_pan_position[23]}}, in_pan_position}
                     + ptg_pkg::TILT_BIAS;

  ptg_mod600 u_pan_mod (
    .clk     (clk),
    .en_s1   (en[0]),
    .en_s2   (en[1]),
    .en_s3   (en[2]),
    .biased  (pan_biased),
    .residue (pan_residue)
  );

  ptg_mod600 u_tilt_mod (
    .clk     (clk),
    .en_s1   (en[0]),
    .en_s2   (en[1]),
    .en_s3   (en[2]),
    .biased  (tilt_biased),
    .residue (tilt_residue)
  );

  ptg_deg_split u_pan_deg (
    .clk     (clk),
    .en      (en[3]),
    .residue (pan_residue),
    .angle   (az_angle)
  );

  ptg_deg_split u_tilt_deg (
    .clk     (clk),
    .en      (en[3]),
    .residue (tilt_residue),
    .angle   (el_angle)
  );

  ptg_move_plan u_plan (
    .clk             (clk),
    .en_s5           (en[4]),
    .en_s6           (en[5]),
    .en_s7           (en[6]),
    .cmd             (cmd_r[CMD_STAGES-1]),
    .az              (az_angle),
    .el              (el_angle),
    .accepted        (out_accepted),
    .pan_step_count  (out_pan_step_count),
    .pan_reverse     (out_pan_reverse),
    .tilt_step_count (out_tilt_step_count),
    .tilt_reverse    (out_tilt_reverse),
    .az_out          (az_final),
    .el_out          (el_final)
  );

  assign out_azimuth_degrees      = az_final.deg;
  assign out_azimuth_hundredths   = az_final.hund;
  assign out_elevation_degrees    = el_final.deg;
  assign out_elevation_hundredths = el_final.hund;

endmodule

>>> rtl/core/ptg_mod600.sv
// Three-stage remainder of a biased step count by 600.
// Uses ptg_pkg for the reciprocal constant.
module ptg_mod600 (
  input  logic        clk,
  input  logic        en_s1,
  input  logic        en_s2,
  input  logic        en_s3,
  input  logic [25:0] biased,
  output logic [9:0]  residue
);

  logic [22:0] v_s1_r;
  logic [2:0]  lo_s1_r;
  logic [22:0] v_s2_r;
  logic [2:0]  lo_s2_r;
  logic [46:0] prod_s2_r;
  logic [9:0]  res_s3_r;

  logic [16:0] quot;
  logic [22:0] diff;
  logic [7:0]  r8;
  logic [7:0]  r_fix;

  // x mod 600 = 8 * ((x >> 3) mod 75) + (x mod 8).
  always_ff @(posedge clk) begin
    if (en_s1) begin
      v_s1_r  <= biased[25:3];
      lo_s1_r <= biased[2:0];
    end
    if (en_s2) begin
      v_s2_r    <= v_s1_r;
      lo_s2_r   <= lo_s1_r;
      prod_s2_r <= 47'(v_s1_r) * 47'(ptg_pkg::MOD_RECIP);
    end
    if (en_s3) begin
      res_s3_r <= {r_fix[6:0], lo_s2_r};
    end
  end

  // The estimated quotient is low by at most one, so one correction suffices.
  always_comb begin
    quot  = prod_s2_r[46:ptg_pkg::MOD_SHIFT];
    diff  = v_s2_r - 23'({6'd0, quot} * 23'(ptg_pkg::MOD_DIV));
    r8    = diff[7:0];
    r_fix = (r8 >= ptg_pkg::MOD_DIV) ? (r8 - ptg_pkg::MOD_DIV) : r8;
  end

  assign residue = res_s3_r;

endmodule

>>> rtl/core/ptg_deg_split.sv
// One stage that turns a remainder in 60-hundredth units into degrees and hundredths.
// Uses ptg_pkg for the angle type and scaling constant.
module ptg_deg_split (
  input  logic            clk,
  input  logic            en,
  input  logic [9:0]      residue,
  output ptg_pkg::angle_t angle
);

  logic [22:0]     prod;
  logic [8:0]      deg;
  logic [10:0]     triple;
  logic [2:0]      frac;
  ptg_pkg::angle_t angle_r;

  // The angle is 60 * residue hundredths; degrees are floor(3 * residue / 5)
  // and the hundredths are 20 times the leftover fifth.
  always_comb begin
    prod   = 23'(residue) * 23'(ptg_pkg::DEG_MUL);
    deg    = prod[ptg_pkg::DEG_SHIFT+8:ptg_pkg::DEG_SHIFT];
    triple = 11'(residue) * 11'd3;
    frac   = 3'(triple - 11'(deg) * 11'd5);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r.deg  <= deg;
      angle_r.hund <= 7'(7'(frac) * 7'd20);
    end
  end

  assign angle = angle_r;

endmodule

>>> rtl/core/ptg_move_plan.sv
// Three stages that form the angle deltas, the motor steps and the net tilt move.
// Uses ptg_pkg for the command and angle types and the turn constants.
module ptg_move_plan (
  input  logic            clk,
  input  logic            en_s5,
  input  logic            en_s6,
  input  logic            en_s7,
  input  ptg_pkg::cmd_t   cmd,
  input  ptg_pkg::angle_t az,
  input  ptg_pkg::angle_t el,
  output logic            accepted,
  output logic [8:0]      pan_step_count,
  output logic            pan_reverse,
  output logic [9:0]      tilt_step_count,
  output logic            tilt_reverse,
  output ptg_pkg::angle_t az_out,
  output ptg_pkg::angle_t el_out
);

  logic            busy_s5_r, busy_s6_r;
  ptg_pkg::angle_t az_s5_r, az_s6_r, el_s5_r, el_s6_r;
  logic [7:0]      abs_az_s5_r;
  logic [8:0]      abs_el_s5_r;
  logic            neg_az_s5_r, neg_el_s5_r, neg_az_s6_r, neg_el_s6_r;
  logic [8:0]      pan_move_s6_r;
  logic [9:0]      tilt_move_s6_r;

  logic            acc_r, pan_rev_r, tilt_rev_r;
  logic [8:0]      pan_cnt_r;
  logic [9:0]      tilt_cnt_r;
  ptg_pkg::angle_t az_out_r, el_out_r;

  logic signed [10:0] daz_raw, daz, del;
  logic [10:0]        abs_az, abs_el;
  logic [21:0]        pan_prod, tilt_prod;
  logic signed [11:0] net;
  logic [11:0]        abs_net;

  // Stage 5: shortest-way azimuth delta and elevation delta.
  always_comb begin
    daz_raw = $signed({2'd0, cmd.azimuth}) - $signed({2'd0, az.deg});
    if (daz_raw > $signed(ptg_pkg::HALF_TURN_DEG)) begin
      daz = daz_raw - $signed(ptg_pkg::FULL_TURN_DEG);
    end else if (daz_raw < -$signed(ptg_pkg::HALF_TURN_DEG)) begin
      daz = daz_raw + $signed(ptg_pkg::FULL_TURN_DEG);
    end else begin
      daz = daz_raw;
    end
    del    = $signed({4'd0, cmd.elevation}) - $signed({2'd0, el.deg});
    abs_az = daz[10] ? 11'(-daz) : 11'(daz);
    abs_el = del[10] ? 11'(-del) : 11'(del);
  end

  // Stage 6: degrees to steps; stage 7: signed net tilt move.
  always_comb begin
    pan_prod  = 22'(abs_az_s5_r) * 22'(ptg_pkg::STEP_MUL);
    tilt_prod = 22'(abs_el_s5_r) * 22'(ptg_pkg::STEP_MUL);
    net       = (neg_az_s6_r ? -$signed(12'(pan_move_s6_r)) : $signed(12'(pan_move_s6_r)))
              + (neg_el_s6_r ? -$signed(12'(tilt_move_s6_r)) : $signed(12'(tilt_move_s6_r)));
    abs_net   = net[11] ? 12'(-net) : 12'(net);
  end

  always_ff @(posedge clk) begin
    if (en_s5) begin
      busy_s5_r   <= cmd.busy;
      az_s5_r     <= az;
      el_s5_r     <= el;
      abs_az_s5_r <= abs_az[7:0];
      abs_el_s5_r <= abs_el[8:0];
      neg_az_s5_r <= daz[10];
      neg_el_s5_r <= del[10];
    end
    if (en_s6) begin
      busy_s6_r      <= busy_s5_r;
      az_s6_r        <= az_s5_r;
      el_s6_r        <= el_s5_r;
      neg_az_s6_r    <= neg_az_s5_r;
      neg_el_s6_r    <= neg_el_s5_r;
      pan_move_s6_r  <= pan_prod[ptg_pkg::STEP_SHIFT+8:ptg_pkg::STEP_SHIFT];
      tilt_move_s6_r <= tilt_prod[ptg_pkg::STEP_SHIFT+9:ptg_pkg::STEP_SHIFT];
    end
    if (en_s7) begin
      if (busy_s6_r) begin
        acc_r      <= 1'b0;
        pan_cnt_r  <= '0;
        pan_rev_r  <= 1'b0;
        tilt_cnt_r <= '0;
        tilt_rev_r <= 1'b0;
        az_out_r   <= '0;
        el_out_r   <= '0;
      end else begin
        acc_r      <= 1'b1;
        pan_cnt_r  <= pan_move_s6_r;
        pan_rev_r  <= neg_az_s6_r;
        tilt_cnt_r <= abs_net[9:0];
        tilt_rev_r <= net[11];
        az_out_r   <= az_s6_r;
        el_out_r   <= el_s6_r;
      end
    end
  end

  assign accepted        = acc_r;
  assign pan_step_count  = pan_cnt_r;
  assign pan_reverse     = pan_rev_r;
  assign tilt_step_count = tilt_cnt_r;
  assign tilt_reverse    = tilt_rev_r;
  assign az_out          = az_out_r;
  assign el_out          = el_out_r;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the pan-tilt goto step planner core.
// Depends only on pan_tilt_goto_step_planner_core and the modules below it.

module tb_top;

  // Cycles in a row with work pending but no item moving on either channel.
  localparam int WATCHDOG_LIMIT = 1000;
  // Extra cycles run after the last result has been checked.
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 450;

  // Angle arithmetic, in hundredths of a degree and whole degrees.
  localparam longint TURN_X100 = 36000;
  localparam longint TILT_HOME_X100 = 9000;
  localparam longint X100_PER_STEP = 60;
  localparam longint HALF_TURN = 180;
  localparam longint FULL_TURN = 360;
  localparam longint ELEV_LOW = 0;
  localparam longint ELEV_HIGH = 90;

  // Receiver behavior. Each mode holds for a stretch of cycles before the
  // next one is drawn, so every stage of the pipeline sees stalls land on it.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_BLOCKS
  } rx_mode_e;

  // One goto request as it crosses the input channel.
  typedef struct packed {
    logic [23:0] pan;
    logic [23:0] tilt;
    logic        busy;
    logic [8:0]  azimuth;
    logic [9:0]  elevation;
  } goto_req_t;

  // One planned move; the field order matches the output ports.
  typedef struct packed {
    logic       accepted;
    logic [8:0] pan_count;
    logic       pan_rev;
    logic [9:0] tilt_count;
    logic       tilt_rev;
    logic [8:0] az_deg;
    logic [6:0] az_hund;
    logic [8:0] el_deg;
    logic [6:0] el_hund;
  } goto_plan_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [23:0] in_pan_position = '0;
  logic [23:0] in_tilt_position = '0;
  logic        in_busy_req = 1'b0;
  logic [8:0]  in_target_azimuth = '0;
  logic [9:0]  in_target_elevation = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_accepted;
  logic [8:0]  out_pan_step_count;
  logic        out_pan_reverse;
  logic [9:0]  out_tilt_step_count;
  logic        out_tilt_reverse;
  logic [8:0]  out_azimuth_degrees;
  logic [6:0]  out_azimuth_hundredths;
  logic [8:0]  out_elevation_degrees;
  logic [6:0]  out_elevation_hundredths;

  pan_tilt_goto_step_planner_core uut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_pan_position          (in_pan_position),
    .in_tilt_position         (in_tilt_position),
    .in_busy_req              (in_busy_req),
    .in_target_azimuth        (in_target_azimuth),
    .in_target_elevation      (in_target_elevation),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_accepted             (out_accepted),
    .out_pan_step_count       (out_pan_step_count),
    .out_pan_reverse          (out_pan_reverse),
    .out_tilt_step_count      (out_tilt_step_count),
    .out_tilt_reverse         (out_tilt_reverse),
    .out_azimuth_degrees      (out_azimuth_degrees),
    .out_azimuth_hundredths   (out_azimuth_hundredths),
    .out_elevation_degrees    (out_elevation_degrees),
    .out_elevation_hundredths (out_elevation_hundredths)
  );

  // Requests waiting to be driven, and planned moves waiting to come out.
  goto_req_t  pending_reqs[$];
  goto_plan_t expected_plans[$];

  goto_req_t  next_req;
  goto_plan_t seen_plan;
  int         req_total = 0;
  int         reqs_sent = 0;
  int         plans_checked = 0;
  int         mismatches = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         rx_mode_left = 0;
  int         rx_block_left = 0;
  rx_mode_e   rx_mode = RX_FREE;
  int         quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Angle in hundredths folded into one turn; % truncates toward zero, so a
  // negative remainder is lifted by a full turn.
  function automatic longint fold_turn(longint a);
    longint r;
    r = a % TURN_X100;
    if (r < 0) r += TURN_X100;
    return r;
  endfunction

  // Whole degrees to full motor steps: floor(deg * 5 / 3), i.e. deg / 1.8 * 3.
  function automatic longint degrees_to_steps(longint deg);
    return (deg * 5) / 3;
  endfunction

  // Expected plan for one request. Busy requests plan nothing and every field,
  // the reported angles included, comes out as zero.
  function automatic goto_plan_t plan_goto(goto_req_t r);
    goto_plan_t p;
    longint pan_l, tilt_l, tgt_el, tgt_az;
    longint pan_x100, tilt_x100, cur_az, cur_el;
    longint d_az, d_el, pan_st, tilt_st, net;
    p = '0;
    if (r.busy) return p;
    pan_l = $signed(r.pan);
    tilt_l = $signed(r.tilt);
    tgt_el = $signed(r.elevation);
    tgt_az = r.azimuth;
    if (tgt_el < ELEV_LOW) tgt_el = ELEV_LOW;
    else if (tgt_el > ELEV_HIGH) tgt_el = ELEV_HIGH;
    // The tilt axis is read relative to pan because the gearing is differential.
    pan_x100 = fold_turn(pan_l * X100_PER_STEP);
    tilt_x100 = fold_turn((tilt_l - pan_l) * X100_PER_STEP + TILT_HOME_X100);
    cur_az = pan_x100 / 100;
    cur_el = tilt_x100 / 100;
    // One correction only, which still keeps targets of 360..511 within a half turn.
    d_az = tgt_az - cur_az;
    if (d_az > HALF_TURN) d_az -= FULL_TURN;
    else if (d_az < -HALF_TURN) d_az += FULL_TURN;
    d_el = tgt_el - cur_el;
    pan_st = degrees_to_steps(d_az < 0 ? -d_az : d_az);
    tilt_st = degrees_to_steps(d_el < 0 ? -d_el : d_el);
    net = (d_az < 0 ? -pan_st : pan_st) + (d_el < 0 ? -tilt_st : tilt_st);
    p.accepted = 1'b1;
    p.pan_count = pan_st[8:0];
    p.pan_rev = (d_az < 0);
    p.tilt_count = (net < 0) ? 10'(-net) : 10'(net);
    p.tilt_rev = (net < 0);
    p.az_deg = cur_az[8:0];
    p.az_hund = 7'(pan_x100 % 100);
    p.el_deg = cur_el[8:0];
    p.el_hund = 7'(tilt_x100 % 100);
    return p;
  endfunction

  task automatic queue_goto(int pan, int tilt, bit busy, int az, int el);
    goto_req_t r;
    r.pan = pan[23:0];
    r.tilt = tilt[23:0];
    r.busy = busy;
    r.azimuth = az[8:0];
    r.elevation = el[9:0];
    pending_reqs.push_back(r);
    req_total++;
  endtask

  // Positions: full range, near home, and near both ends of the counter.
  function automatic int pick_position();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(3))
      0: return $signed(raw[23:0]);
      1: return int'($urandom_range(2400)) - 1200;
      2: return 8388607 - int'($urandom_range(1000));
      default: return -8388608 + int'($urandom_range(1000));
    endcase
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("result %0d: %s is %0d, expected %0d", plans_checked, field, got, want);
    mismatches++;
  endtask

  task automatic check_plan(goto_plan_t got, goto_plan_t want);
    if (got.accepted !== want.accepted)
      report_mismatch("accepted", got.accepted, want.accepted);
    if (got.pan_count !== want.pan_count)
      report_mismatch("pan_step_count", got.pan_count, want.pan_count);
    if (got.pan_rev !== want.pan_rev)
      report_mismatch("pan_reverse", got.pan_rev, want.pan_rev);
    if (got.tilt_count !== want.tilt_count)
      report_mismatch("tilt_step_count", got.tilt_count, want.tilt_count);
    if (got.tilt_rev !== want.tilt_rev)
      report_mismatch("tilt_reverse", got.tilt_rev, want.tilt_rev);
    if (got.az_deg !== want.az_deg)
      report_mismatch("azimuth_degrees", got.az_deg, want.az_deg);
    if (got.az_hund !== want.az_hund)
      report_mismatch("azimuth_hundredths", got.az_hund, want.az_hund);
    if (got.el_deg !== want.el_deg)
      report_mismatch("elevation_degrees", got.el_deg, want.el_deg);
    if (got.el_hund !== want.el_hund)
      report_mismatch("elevation_hundredths", got.el_hund, want.el_hund);
  endtask

  // Sender. It works in bursts of random length separated by random gaps, and
  // it holds the item steady while in_stall is high. The prediction is made
  // from the port values at the edge where the item is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_plans.push_back(plan_goto({in_pan_position, in_tilt_position, in_busy_req,
                                            in_target_azimuth, in_target_elevation}));
        reqs_sent++;
      end
      if (in_valid && in_stall) begin
        // Held: nothing on the input channel may change.
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        in_pan_position <= next_req.pan;
        in_tilt_position <= next_req.tilt;
        in_busy_req <= next_req.busy;
        in_target_azimuth <= next_req.azimuth;
        in_target_elevation <= next_req.elevation;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(24, 1);
          // Half of the bursts run straight on; a few gaps are long.
          case ($urandom_range(7))
            0, 1, 2, 3: gap_left <= 0;
            4, 5, 6: gap_left <= $urandom_range(8, 1);
            default: gap_left <= $urandom_range(40, 20);
          endcase
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern. A mode is drawn at random and kept for a stretch:
  // no stalls, sparse stalls, dense stalls, or long stalled blocks that let
  // the whole pipeline fill and push back on the sender.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(3));
      rx_mode_left <= $urandom_range(200, 50);
      out_stall <= 1'b0;
    end else begin
      rx_mode_left <= rx_mode_left - 1;
      case (rx_mode)
        RX_FREE: out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(3) != 0);
        default: begin
          if (rx_block_left == 0) begin
            out_stall <= ~out_stall;
            rx_block_left <= out_stall ? $urandom_range(10, 1) : $urandom_range(30, 5);
          end else begin
            rx_block_left <= rx_block_left - 1;
          end
        end
      endcase
    end
  end

  // Result checker: every item taken on the output channel is compared field
  // by field with the oldest planned move still outstanding.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_plan = {out_accepted, out_pan_step_count, out_pan_reverse, out_tilt_step_count,
                   out_tilt_reverse, out_azimuth_degrees, out_azimuth_hundredths,
                   out_elevation_degrees, out_elevation_hundredths};
      if (expected_plans.size() == 0) begin
        $display("result %0d: arrived with no request outstanding", plans_checked);
        mismatches++;
      end else begin
        check_plan(seen_plan, expected_plans.pop_front());
      end
      plans_checked++;
    end
  end

  // Watchdog: counts cycles in which work is outstanding but no item moves.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending_reqs.size() == 0 && expected_plans.size() == 0 && !in_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Directed requests. Home position: azimuth 0.00, elevation 90.00.
    queue_goto(0, 0, 1'b0, 0, 90);               // already there, zero move both ways
    queue_goto(0, 0, 1'b0, 180, 0);              // exactly a half turn forward
    queue_goto(300, 300, 1'b0, 0, 90);           // exactly a half turn back
    queue_goto(0, 0, 1'b0, 181, 45);             // just past half, goes the other way
    queue_goto(0, 0, 1'b0, 359, 0);
    queue_goto(0, 0, 1'b0, 360, 90);             // targets past a full turn
    queue_goto(0, 0, 1'b0, 511, 90);
    queue_goto(150, 0, 1'b0, 511, 30);
    queue_goto(0, 0, 1'b0, 10, -512);            // elevation clamped at the bottom
    queue_goto(0, 0, 1'b0, 10, -1);
    queue_goto(0, 0, 1'b0, 10, 91);              // and at the top
    queue_goto(0, 0, 1'b0, 10, 511);
    queue_goto(1, 1, 1'b0, 0, 90);               // sub-degree angles
    queue_goto(-1, -1, 1'b0, 0, 90);             // negative count wraps to 359.40
    queue_goto(0, 299, 1'b0, 200, 0);            // large net tilt move
    queue_goto(0, -151, 1'b0, 90, 90);
    queue_goto(8388607, -8388608, 1'b0, 0, 0);   // counter extremes
    queue_goto(-8388608, 8388607, 1'b0, 359, 90);
    queue_goto(8388607, 8388607, 1'b0, 511, 511);
    queue_goto(-8388608, -8388608, 1'b0, 0, -512);
    queue_goto(-1, 0, 1'b0, 511, 0);
    queue_goto(0, 0, 1'b1, 0, 0);                // busy: nothing planned
    queue_goto(-1, -1, 1'b1, 511, -1);
    queue_goto(8388607, -8388608, 1'b1, 359, 90);

    // Random requests. Most keep tilt close to pan so the elevation lands near
    // the working range and small or zero moves come up often.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      int pan, tilt, az, el;
      pan = pick_position();
      if ($urandom_range(2) != 0)
        tilt = pan + int'($urandom_range(700)) - 250;
      else
        tilt = pick_position();
      az = ($urandom_range(7) == 0) ? $urandom_range(511, 360) : $urandom_range(359);
      el = ($urandom_range(4) == 0) ? int'($urandom_range(1023)) - 512
                                    : int'($urandom_range(110)) - 10;
      queue_goto(pan, tilt, ($urandom_range(4) == 0), az, el);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so the sender's bookkeeping has settled.
    @(negedge clk);
    while (reqs_sent != req_total || expected_plans.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && expected_plans.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
rtl/core/ptg_pkg.sv
rtl/core/ptg_mod600.sv
rtl/core/ptg_deg_split.sv
rtl/core/ptg_move_plan.sv
rtl/core/pan_tilt_goto_step_planner_core.sv
bench/tb_top.sv
